// ===== src/hgg_pkg.sv =====
// Package for the half-gate garbler: widths, operation codes, state machine
// type and AES helper functions (S-box, round pieces, key schedule step).
// No dependencies.
package hgg_pkg;

    localparam int WIRE_COUNT = 4096;
    localparam int WIRE_AW    = $clog2(WIRE_COUNT);

    typedef enum logic [2:0] {
        K_WRITE = 3'd0,
        K_COPY  = 3'd1,
        K_XOR   = 3'd2,
        K_XNOR  = 3'd3,
        K_NOT   = 3'd4,
        K_HALF  = 3'd5,
        K_READ  = 3'd6,
        K_NONE  = 3'd7
    } t_kind;

    localparam logic [1:0] CFG_KEY_HI = 2'd0;
    localparam logic [1:0] CFG_KEY_LO = 2'd1;
    localparam logic [1:0] CFG_OFF_HI = 2'd2;
    localparam logic [1:0] CFG_OFF_LO = 2'd3;

    localparam logic RES_TABLE = 1'b0;
    localparam logic RES_LABEL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_H0,
        S_H1,
        S_OUT
    } t_state;

    // control from the top level to the AES core
    typedef struct packed {
        logic         start;
        logic [127:0] blk_a;
        logic [127:0] blk_b;
    } t_aes_req;

    typedef struct packed {
        logic         done;
        logic [127:0] hash_a;
        logic [127:0] hash_b;
    } t_aes_rsp;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // byte j of the state is bits 8j+7:8j
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic last);
        logic [127:0] sb, sr, mc;
        logic [7:0]   a0, a1, a2, a3, al;
        sb = '0;
        sr = '0;
        mc = '0;
        for (int j = 0; j < 16; j++) sb[8*j +: 8] = sbox(s[8*j +: 8]);
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                sr[8*(j+4*c) +: 8] = sb[8*(j + 4*((c+j)%4)) +: 8];
        for (int c = 0; c < 4; c++) begin
            a0 = sr[8*(4*c)   +: 8];
            a1 = sr[8*(4*c+1) +: 8];
            a2 = sr[8*(4*c+2) +: 8];
            a3 = sr[8*(4*c+3) +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mc[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return (last ? sr : mc) ^ k;
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [3:0] r);
        logic [31:0]  w3, t;
        logic [127:0] n;
        w3 = k[127:96];
        t  = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]),
              sbox(w3[15:8]) ^ rcon(r)};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

endpackage

// ===== src/hgg_if.sv =====
// Valid/ready channel interfaces for the half-gate garbler.
// No dependencies.
interface hgg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [11:0] wire_a;
    logic [11:0] wire_b;
    logic [11:0] wire_dest;
    logic [2:0]  invert_flags;
    logic [31:0] clock_index;
    logic [30:0] gate_index;
    logic [63:0] zero_label_high;
    logic [63:0] zero_label_low;
    logic [63:0] one_label_high;
    logic [63:0] one_label_low;
    modport source (output valid, kind, wire_a, wire_b, wire_dest, invert_flags, clock_index,
                    gate_index, zero_label_high, zero_label_low, one_label_high,
                    one_label_low, input ready);
    modport sink (input valid, kind, wire_a, wire_b, wire_dest, invert_flags, clock_index,
                  gate_index, zero_label_high, zero_label_low, one_label_high,
                  one_label_low, output ready);
endinterface

interface hgg_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [63:0] first_high;
    logic [63:0] first_low;
    logic [63:0] second_high;
    logic [63:0] second_low;
    modport source (output valid, result_kind, first_high, first_low, second_high,
                    second_low, input ready);
    modport sink (input valid, result_kind, first_high, first_low, second_high,
                  second_low, output ready);
endinterface

interface hgg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/half_gate_garbler_top.sv =====
// Half-gate garbler: label store plus fixed-key AES hash.
// Flow: write taken every cycle while no result waits; copy/xor/xnor/not read the store
// in S_RD and write back before the next word can be taken; read loads the result register
// in the cycle after it is taken. Half gate: store read, two passes of a pair of 10-round
// AES cores, store write and table out, output state. A waiting result holds off the input.
// Reset (synchronous, active low) clears control and config; label store not cleared.
module half_gate_garbler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hgg_in_if.sink      i_in,
    hgg_out_if.source   o_out,
    hgg_cfg_if.sink     i_cfg
);
    hgg_pkg::t_state r_state, n_state;

    // configuration words
    logic [63:0] r_key_hi, r_key_lo, r_off_hi, r_off_lo;

    // captured item
    hgg_pkg::t_kind r_kind;
    logic [hgg_pkg::WIRE_AW-1:0] r_wa, r_wb, r_wd;
    logic [2:0]   r_flags;
    logic [127:0] r_t0;
    logic [127:0] r_a0, r_a1, r_b0, r_b1, r_h0;

    // output register
    logic         r_ovalid;
    logic         r_okind;
    logic [255:0] r_odata;

    logic         accept, ram_we;
    logic [255:0] qa, qb, ram_wd;
    logic [hgg_pkg::WIRE_AW-1:0] ram_wa;
    logic [127:0] rr, ta0, ta1, tb0, tb1, t_row1, c_lab;
    hgg_pkg::t_aes_req aes_req;
    hgg_pkg::t_aes_rsp aes_rsp;

    assign rr = {r_off_hi, r_off_lo};
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == hgg_pkg::S_IDLE) && !r_ovalid;
    assign accept      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_off_hi <= '0;
            r_off_lo <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hgg_pkg::CFG_KEY_HI: r_key_hi <= i_cfg.data;
                hgg_pkg::CFG_KEY_LO: r_key_lo <= i_cfg.data;
                hgg_pkg::CFG_OFF_HI: r_off_hi <= i_cfg.data;
                hgg_pkg::CFG_OFF_LO: r_off_lo <= i_cfg.data;
                default: ;
            endcase
        end
    end

    hgg_label_ram u_ram (
        .i_clk (i_clk),
        .i_ra  (accept ? i_in.wire_a[hgg_pkg::WIRE_AW-1:0] : r_wa),
        .i_rb  (accept ? i_in.wire_b[hgg_pkg::WIRE_AW-1:0] : r_wb),
        .i_we  (ram_we),
        .i_wa  (ram_wa),
        .i_wd  (ram_wd),
        .o_qa  (qa),
        .o_qb  (qb)
    );

    // label pairs with the invert flags applied (valid in S_RD)
    assign ta0 = r_flags[0] ? qa[255:128] : qa[127:0];
    assign ta1 = r_flags[0] ? qa[127:0]   : qa[255:128];
    assign tb0 = r_flags[1] ? qb[255:128] : qb[127:0];
    assign tb1 = r_flags[1] ? qb[127:0]   : qb[255:128];

    // first pass hashes the A labels, second pass the B labels
    always_comb begin
        aes_req.start = (r_state == hgg_pkg::S_RD && r_kind == hgg_pkg::K_HALF) ||
                        (r_state == hgg_pkg::S_H0 && aes_rsp.done);
        if (r_state == hgg_pkg::S_RD) begin
            aes_req.blk_a = ta0 ^ r_t0;
            aes_req.blk_b = ta1 ^ r_t0;
        end else begin
            aes_req.blk_a = r_b0 ^ {r_t0[127:1], 1'b1};
            aes_req.blk_b = r_b1 ^ {r_t0[127:1], 1'b1};
        end
    end

    hgg_aes u_aes (
        .i_clk (i_clk),
        .i_rst_n (i_rst_n),
        .i_key (({r_key_hi, r_key_lo})),
        .i_req (aes_req),
        .o_rsp (aes_rsp)
    );

    // r_h0 holds H(A0^t0), r_a1 reused for T0 after pass one
    // T1 = H(B0^t1) ^ H(B1^t1) ^ A0
    assign t_row1 = aes_rsp.hash_a ^ aes_rsp.hash_b ^ r_a0;
    assign c_lab  = (r_a0[0] ? (r_h0 ^ r_a1) : r_h0) ^
                    (r_b0[0] ? (aes_rsp.hash_a ^ t_row1 ^ r_a0) : aes_rsp.hash_a);

    always_comb begin
        n_state = r_state;
        case (r_state)
            hgg_pkg::S_IDLE:
                if (accept && i_in.kind != hgg_pkg::K_WRITE &&
                    i_in.kind != hgg_pkg::K_NONE) n_state = hgg_pkg::S_RD;
            hgg_pkg::S_RD:
                n_state = (r_kind == hgg_pkg::K_HALF) ? hgg_pkg::S_H0 : hgg_pkg::S_IDLE;
            hgg_pkg::S_H0:
                if (aes_rsp.done) n_state = hgg_pkg::S_H1;
            hgg_pkg::S_H1:
                if (aes_rsp.done) n_state = hgg_pkg::S_OUT;
            hgg_pkg::S_OUT:
                n_state = hgg_pkg::S_IDLE;
            default:
                n_state = hgg_pkg::S_IDLE;
        endcase
    end

    // store write selection
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_wd;
        ram_wd = qa;
        if (accept && i_in.kind == hgg_pkg::K_WRITE) begin
            ram_we = 1'b1;
            ram_wa = i_in.wire_dest[hgg_pkg::WIRE_AW-1:0];
            ram_wd = {i_in.one_label_high, i_in.one_label_low,
                      i_in.zero_label_high, i_in.zero_label_low};
        end else if (r_state == hgg_pkg::S_RD) begin
            case (r_kind)
                hgg_pkg::K_COPY: ram_we = 1'b1;
                hgg_pkg::K_XOR: begin
                    ram_we = 1'b1;
                    ram_wd = {qa[255:128] ^ qb[127:0], qa[127:0] ^ qb[127:0]};
                end
                hgg_pkg::K_XNOR: begin
                    ram_we = 1'b1;
                    ram_wd = {qa[127:0] ^ qb[127:0], qa[255:128] ^ qb[127:0]};
                end
                hgg_pkg::K_NOT: begin
                    ram_we = 1'b1;
                    ram_wd = {qa[127:0], qa[255:128]};
                end
                default: ram_we = 1'b0;
            endcase
        end else if (r_state == hgg_pkg::S_H1 && aes_rsp.done) begin
            ram_we = 1'b1;
            ram_wd = r_flags[2] ? {c_lab, c_lab ^ rr} : {c_lab ^ rr, c_lab};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hgg_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end else if ((r_state == hgg_pkg::S_RD && r_kind == hgg_pkg::K_READ) ||
                         (r_state == hgg_pkg::S_H1 && aes_rsp.done)) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= hgg_pkg::t_kind'(i_in.kind);
            r_wa    <= i_in.wire_a[hgg_pkg::WIRE_AW-1:0];
            r_wb    <= i_in.wire_b[hgg_pkg::WIRE_AW-1:0];
            r_wd    <= i_in.wire_dest[hgg_pkg::WIRE_AW-1:0];
            r_flags <= i_in.invert_flags;
            r_t0    <= {32'd0, i_in.clock_index, 32'd0, i_in.gate_index, 1'b0};
        end
        if (r_state == hgg_pkg::S_RD) begin
            r_a0    <= ta0;
            r_b0    <= tb0;
            r_b1    <= tb1;
            r_okind <= hgg_pkg::RES_LABEL;
            r_odata <= qa;
        end
        if (r_state == hgg_pkg::S_H0 && aes_rsp.done) begin
            r_h0 <= aes_rsp.hash_a;
            r_a1 <= aes_rsp.hash_a ^ aes_rsp.hash_b ^ (r_b0[0] ? rr : '0);
        end
        if (r_state == hgg_pkg::S_H1 && aes_rsp.done) begin
            r_okind <= hgg_pkg::RES_TABLE;
            r_odata <= {t_row1, r_a1};
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.result_kind = r_okind;
    assign o_out.first_high  = r_odata[127:64];
    assign o_out.first_low   = r_odata[63:0];
    assign o_out.second_high = r_odata[255:192];
    assign o_out.second_low  = r_odata[191:128];
endmodule

// ===== src/hgg_label_ram.sv =====
// Wire label store: one 256-bit pair per wire, synchronous read.
// Two read ports and one write port. Depends on hgg_pkg.
module hgg_label_ram (
    input  logic                       i_clk,
    input  logic [hgg_pkg::WIRE_AW-1:0] i_ra,
    input  logic [hgg_pkg::WIRE_AW-1:0] i_rb,
    input  logic                       i_we,
    input  logic [hgg_pkg::WIRE_AW-1:0] i_wa,
    input  logic [255:0]               i_wd,
    output logic [255:0]               o_qa,
    output logic [255:0]               o_qb
);
    // {true, false}, each label {high, low}
    logic [255:0] mem [hgg_pkg::WIRE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        o_qa <= mem[i_ra];
        o_qb <= mem[i_rb];
    end
endmodule

// ===== src/hgg_aes.sv =====
// Two round-iterated AES-128 cores sharing one on-the-fly key schedule;
// returns AES(x)^x for both blocks. Depends on hgg_pkg.
module hgg_aes (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [127:0]      i_key,
    input  hgg_pkg::t_aes_req i_req,
    output hgg_pkg::t_aes_rsp o_rsp
);
    logic [127:0] r_sa, r_sb, r_xa, r_xb, r_k;
    logic [3:0]   r_rnd;
    logic         r_busy, r_done;
    logic [127:0] n_k;

    assign n_k = hgg_pkg::key_step(r_k, r_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rnd  <= 4'd1;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 4'd1;
                if (r_rnd == 4'd10) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sa <= i_req.blk_a ^ i_key;
            r_sb <= i_req.blk_b ^ i_key;
            r_xa <= i_req.blk_a;
            r_xb <= i_req.blk_b;
            r_k  <= i_key;
        end else if (r_busy) begin
            r_sa <= hgg_pkg::aes_round(r_sa, n_k, r_rnd == 4'd10);
            r_sb <= hgg_pkg::aes_round(r_sb, n_k, r_rnd == 4'd10);
            r_k  <= n_k;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.hash_a = r_sa ^ r_xa;
    assign o_rsp.hash_b = r_sb ^ r_xb;
endmodule
